>>> rtl/ellipse_point_generator_defines.svh
// ----------------------------------------------------------------------------
// Ellipse point generator assertion macros
// Concurrent assertion shorthands clocked on clk_i, with and without reset
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_POINT_GENERATOR_DEFINES_SVH
`define ELLIPSE_POINT_GENERATOR_DEFINES_SVH

// checked only while out of reset
`define EPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define EPG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/epg_pkg.sv
// ----------------------------------------------------------------------------
// Ellipse point generator package
// Widths, codes, trig constants and bundles shared by the block's modules
// ----------------------------------------------------------------------------
package epg_pkg;

  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_SAMPLES = 10000;
  localparam int MIN_SAMPLES = 4;

  localparam int IDX_W      = 14;
  localparam int AXIS_W     = 31;
  localparam int ECC_W      = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  localparam int HORNER_STEPS = 6;
  localparam int SIN_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_AXIS  = 3'd1,
    ST_ORDER = 3'd2,
    ST_COUNT = 3'd3,
    ST_INDEX = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_MAJOR    = 3'd2,
    CFG_MINOR    = 3'd3,
    CFG_HORIZ    = 3'd4,
    CFG_COUNT    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [AXIS_W-1:0]     major_axis;
    logic [AXIS_W-1:0]     minor_axis;
    logic                  horizontal;
    logic [IDX_W-1:0]      count;
  } cfg_t;

  typedef struct packed {
    logic              busy;
    logic [AXIS_W-1:0] focal;
    logic [ECC_W-1:0]  ecc;
  } focal_t;

endpackage

>>> rtl/epg_focal.sv
// ----------------------------------------------------------------------------
// Ellipse focal unit
// Recomputes focal distance and eccentricity after each register write
// ----------------------------------------------------------------------------
module epg_focal (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  epg_pkg::cfg_t  cfg_i,
  output epg_pkg::focal_t focal_o
);

  localparam int SQRT_STEPS = 31;
  localparam int CNT_W      = $clog2(SQRT_STEPS);
  localparam int FB         = epg_pkg::FRAC_BITS;

  typedef enum logic [1:0] {FS_IDLE, FS_MUL, FS_SQRT, FS_DIV} state_e;

  state_e                          state_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [61:0]                     rad_q, root_q, bit_q;
  logic [31:0]                     rem_q;
  logic [FB-1:0]                   quo_q;
  logic [epg_pkg::AXIS_W-1:0]      focal_q;
  logic [epg_pkg::ECC_W-1:0]       ecc_q;

  logic [61:0] sq_sum, root_d;
  logic        sq_ge;
  logic [31:0] dv_tr;
  logic        dv_ge;
  logic [FB-1:0] quo_d;

  always_comb begin
    sq_sum = root_q + bit_q;
    sq_ge  = rad_q >= sq_sum;
    root_d = sq_ge ? (root_q >> 1) + bit_q : root_q >> 1;
    dv_tr  = {rem_q[30:0], 1'b0};
    dv_ge  = dv_tr >= {1'b0, cfg_i.major_axis};
    quo_d  = {quo_q[FB-2:0], dv_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
      focal_q <= '0;
      ecc_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= FS_MUL;
    end else begin
      case (state_q)
        FS_IDLE: begin
        end
        FS_MUL: begin
          if (cfg_i.major_axis >= cfg_i.minor_axis) begin
            rad_q <= 62'(63'(cfg_i.major_axis - cfg_i.minor_axis) *
                         (63'(cfg_i.major_axis) + 63'(cfg_i.minor_axis)));
          end else begin
            rad_q <= '0;
          end
          root_q  <= '0;
          bit_q   <= 62'(1) << 60;
          cnt_q   <= '0;
          state_q <= FS_SQRT;
        end
        FS_SQRT: begin
          if (sq_ge) rad_q <= rad_q - sq_sum;
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
            focal_q <= root_d[epg_pkg::AXIS_W-1:0];
            rem_q   <= {1'b0, root_d[epg_pkg::AXIS_W-1:0]};
            cnt_q   <= '0;
            state_q <= FS_DIV;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        FS_DIV: begin
          rem_q <= dv_ge ? dv_tr - {1'b0, cfg_i.major_axis} : dv_tr;
          quo_q <= quo_d;
          if (cnt_q == CNT_W'(FB - 1)) begin
            ecc_q   <= epg_pkg::ECC_W'(quo_d);
            state_q <= FS_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= FS_IDLE;
      endcase
    end
  end

  assign focal_o.busy  = state_q != FS_IDLE;
  assign focal_o.focal = focal_q;
  assign focal_o.ecc   = ecc_q;

endmodule

>>> rtl/epg_pipe.sv
// ----------------------------------------------------------------------------
// Ellipse point pipeline
// Phase division, Taylor sin/cos, axis scaling and saturating sums
// ----------------------------------------------------------------------------
module epg_pipe #(
  parameter int unsigned MAX_SAMPLES = epg_pkg::MAX_SAMPLES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  epg_pkg::cfg_t                   cfg_i,
  input  epg_pkg::focal_t                 focal_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [epg_pkg::IDX_W-1:0]       sample_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [epg_pkg::COORD_BITS-1:0]  point_x_o,
  output logic [epg_pkg::COORD_BITS-1:0]  point_y_o,
  output logic [epg_pkg::COORD_BITS-1:0]  focus_low_x_o,
  output logic [epg_pkg::COORD_BITS-1:0]  focus_low_y_o,
  output logic [epg_pkg::COORD_BITS-1:0]  focus_high_x_o,
  output logic [epg_pkg::COORD_BITS-1:0]  focus_high_y_o,
  output logic [epg_pkg::AXIS_W-1:0]      focal_distance_o,
  output logic [epg_pkg::ECC_W-1:0]       eccentricity_o
);

  localparam int CW         = epg_pkg::COORD_BITS;
  localparam int IW         = epg_pkg::IDX_W;
  localparam int HS         = epg_pkg::HORNER_STEPS;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 32 / DIV_STEPS;
  localparam int ST_QUAD    = DIV_STAGES + 1;
  localparam int ST_RAD     = ST_QUAD + 1;
  localparam int ST_SQR     = ST_RAD + 1;
  localparam int ST_HORN    = ST_SQR + 1;
  localparam int ST_SIN     = ST_HORN + 3 * HS;
  localparam int ST_MUL     = ST_SIN + 1;
  localparam int ST_OUT     = ST_MUL + 1;
  localparam int NS         = ST_OUT + 1;

  typedef struct packed {
    epg_pkg::status_e status;
    logic             last;
    logic [IW-1:0]    rem;
    logic [31:0]      num;
  } div_t;

  typedef struct packed {
    epg_pkg::status_e status;
    logic [1:0]       quad;
    logic             swap;
    logic [29:0]      x;
    logic [29:0]      x2;
  } trig_t;

  function automatic div_t div_step(div_t v, logic [IW-1:0] dv);
    logic [IW:0] tr;
    logic        ge;
    div_t        r;
    r = v;
    for (int i = 0; i < DIV_STEPS; i++) begin
      tr    = {r.rem, r.num[31]};
      ge    = tr >= {1'b0, dv};
      r.num = {r.num[30:0], ge};
      r.rem = ge ? IW'(tr - {1'b0, dv}) : tr[IW-1:0];
    end
    return r;
  endfunction

  function automatic logic [30:0] horner_fix(logic [29:0] u, logic [29:0] qe,
                                             logic [7:0] dv);
    logic [29:0] rm;
    logic [29:0] q;
    rm = u - 30'(38'(qe) * 38'(dv));
    q  = (rm >= 30'(dv)) ? qe + 30'd1 : qe;
    return epg_pkg::Q30_ONE - {1'b0, q};
  endfunction

  function automatic logic [CW-1:0] sat_coord(logic signed [CW+1:0] v);
    if (v > $signed({3'b000, {(CW-1){1'b1}}})) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (v < $signed({3'b111, {(CW-1){1'b0}}})) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return v[CW-1:0];
    end
  endfunction

  // stall chain: a stage moves when empty or when the next one moves
  logic [NS-1:0] vld_q, en, vld_in;
  logic          in_go;

  assign en[NS-1] = ~vld_q[NS-1] | out_ready_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  assign in_go      = in_valid_i & ~focal_i.busy;
  assign in_ready_o = en[0] & ~focal_i.busy;
  assign vld_in     = {vld_q[NS-2:0], in_go};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  // intake and status
  logic [IW-1:0]    dvs;
  epg_pkg::status_e st_d;
  div_t             dq [DIV_STAGES+1];

  assign dvs = cfg_i.count - IW'(1);

  always_comb begin
    if (cfg_i.major_axis == '0 || cfg_i.minor_axis == '0) begin
      st_d = epg_pkg::ST_AXIS;
    end else if (cfg_i.count < IW'(epg_pkg::MIN_SAMPLES) ||
                 cfg_i.count > IW'(MAX_SAMPLES)) begin
      st_d = epg_pkg::ST_COUNT;
    end else if (cfg_i.major_axis < cfg_i.minor_axis) begin
      st_d = epg_pkg::ST_ORDER;
    end else if (sample_index_i >= cfg_i.count) begin
      st_d = epg_pkg::ST_INDEX;
    end else begin
      st_d = epg_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dq[0].status <= st_d;
      dq[0].last   <= sample_index_i == dvs;
      dq[0].rem    <= (sample_index_i == dvs) ? '0 : sample_index_i;
      dq[0].num    <= 32'(dvs >> 1);
    end
  end

  // phase = round(i * 2^32 / (N-1)), four quotient bits a stage
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[s]) dq[s] <= div_step(dq[s-1], dvs);
    end
  end

  // quadrant and octant fold; x holds the folded angle here
  trig_t       quad_q;
  logic [31:0] phase;
  logic [29:0] frac;

  assign phase = dq[DIV_STAGES].last ? '0 : dq[DIV_STAGES].num;
  assign frac  = phase[29:0];

  always_ff @(posedge clk_i) begin
    if (en[ST_QUAD]) begin
      quad_q.status <= dq[DIV_STAGES].status;
      quad_q.quad   <= phase[31:30];
      quad_q.swap   <= frac > 30'h2000_0000;
      quad_q.x      <= (frac > 30'h2000_0000) ? 30'(epg_pkg::Q30_ONE - {1'b0, frac})
                                              : frac;
      quad_q.x2     <= '0;
    end
  end

  // radians and square
  trig_t       rad_q, sqr_q, rad_d, sqr_d;
  logic [60:0] rad_prod;
  logic [59:0] sqr_prod;

  assign rad_prod = 61'(quad_q.x) * 61'(epg_pkg::PI_HALF_Q30);
  assign sqr_prod = 60'(rad_q.x) * 60'(rad_q.x);

  always_comb begin
    rad_d    = quad_q;
    rad_d.x  = rad_prod[59:30];
    sqr_d    = rad_q;
    sqr_d.x2 = sqr_prod[59:30];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_RAD]) begin
      rad_q <= rad_d;
    end
    if (en[ST_SQR]) begin
      sqr_q <= sqr_d;
    end
  end

  // Horner series, sin and cos lanes side by side, three stages a term
  trig_t       ha_car_q [HS];
  trig_t       hb_car_q [HS];
  trig_t       hc_car_q [HS];
  logic [29:0] ha_us_q [HS], ha_uc_q [HS];
  logic [29:0] hb_us_q [HS], hb_uc_q [HS];
  logic [29:0] hb_qs_q [HS], hb_qc_q [HS];
  logic [30:0] hc_ts_q [HS], hc_tc_q [HS];

  for (genvar j = 0; j < HS; j++) begin : g_horn
    localparam logic [30:0] MS = 31'((64'd1 << 31) / epg_pkg::SIN_DIV[j]);
    localparam logic [30:0] MC = 31'((64'd1 << 31) / epg_pkg::COS_DIV[j]);
    localparam logic [7:0]  DS = 8'(epg_pkg::SIN_DIV[j]);
    localparam logic [7:0]  DC = 8'(epg_pkg::COS_DIV[j]);

    trig_t       car_in;
    logic [30:0] ts_in, tc_in;
    logic [60:0] pa_s, pa_c, pb_s, pb_c;

    if (j == 0) begin : g_first
      assign car_in = sqr_q;
      assign ts_in  = epg_pkg::Q30_ONE;
      assign tc_in  = epg_pkg::Q30_ONE;
    end else begin : g_next
      assign car_in = hc_car_q[j-1];
      assign ts_in  = hc_ts_q[j-1];
      assign tc_in  = hc_tc_q[j-1];
    end

    assign pa_s = 61'(car_in.x2) * 61'(ts_in);
    assign pa_c = 61'(car_in.x2) * 61'(tc_in);
    assign pb_s = 61'(ha_us_q[j]) * 61'(MS);
    assign pb_c = 61'(ha_uc_q[j]) * 61'(MC);

    always_ff @(posedge clk_i) begin
      if (en[ST_HORN + 3*j]) begin
        ha_car_q[j] <= car_in;
        ha_us_q[j]  <= pa_s[59:30];
        ha_uc_q[j]  <= pa_c[59:30];
      end
      if (en[ST_HORN + 3*j + 1]) begin
        hb_car_q[j] <= ha_car_q[j];
        hb_us_q[j]  <= ha_us_q[j];
        hb_uc_q[j]  <= ha_uc_q[j];
        hb_qs_q[j]  <= pb_s[60:31];
        hb_qc_q[j]  <= pb_c[60:31];
      end
      if (en[ST_HORN + 3*j + 2]) begin
        hc_car_q[j] <= hb_car_q[j];
        hc_ts_q[j]  <= horner_fix(hb_us_q[j], hb_qs_q[j], DS);
        hc_tc_q[j]  <= horner_fix(hb_uc_q[j], hb_qc_q[j], DC);
      end
    end
  end

  // sin = x * t, then quadrant rotation into magnitude and sign
  trig_t       sin_car_q;
  logic [30:0] sin_s_q, sin_c_q;
  logic [60:0] sin_prod;

  assign sin_prod = 61'(hc_car_q[HS-1].x) * 61'(hc_ts_q[HS-1]);

  always_ff @(posedge clk_i) begin
    if (en[ST_SIN]) begin
      sin_car_q <= hc_car_q[HS-1];
      sin_s_q   <= {1'b0, sin_prod[59:30]};
      sin_c_q   <= hc_tc_q[HS-1];
    end
  end

  logic [30:0] s0, c0, mag_maj, mag_min;

  assign c0      = sin_car_q.swap ? sin_s_q : sin_c_q;
  assign s0      = sin_car_q.swap ? sin_c_q : sin_s_q;
  assign mag_maj = sin_car_q.quad[0] ? s0 : c0;
  assign mag_min = sin_car_q.quad[0] ? c0 : s0;

  epg_pkg::status_e mul_st_q;
  logic             mul_neg_maj_q, mul_neg_min_q;
  logic [61:0]      mul_pmaj_q, mul_pmin_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      mul_st_q      <= sin_car_q.status;
      mul_neg_maj_q <= sin_car_q.quad[0] ^ sin_car_q.quad[1];
      mul_neg_min_q <= sin_car_q.quad[1];
      mul_pmaj_q    <= 62'(cfg_i.major_axis) * 62'(mag_maj);
      mul_pmin_q    <= 62'(cfg_i.minor_axis) * 62'(mag_min);
    end
  end

  // rounding, centre sums and saturation
  logic [61:0]            rnd_maj, rnd_min;
  logic signed [CW+1:0]   t_maj, t_min, t_x, t_y, cx, cy, fo, fx, fy;

  always_comb begin
    rnd_maj = mul_pmaj_q + 62'(1 << 29);
    rnd_min = mul_pmin_q + 62'(1 << 29);
    t_maj   = mul_neg_maj_q ? -$signed((CW+2)'(rnd_maj[61:30]))
                            :  $signed((CW+2)'(rnd_maj[61:30]));
    t_min   = mul_neg_min_q ? -$signed((CW+2)'(rnd_min[61:30]))
                            :  $signed((CW+2)'(rnd_min[61:30]));
    cx      = $signed({{2{cfg_i.center_x[CW-1]}}, cfg_i.center_x});
    cy      = $signed({{2{cfg_i.center_y[CW-1]}}, cfg_i.center_y});
    fo      = $signed((CW+2)'(focal_i.focal));
    t_x     = cfg_i.horizontal ? t_maj : t_min;
    t_y     = cfg_i.horizontal ? t_min : t_maj;
    fx      = cfg_i.horizontal ? fo : '0;
    fy      = cfg_i.horizontal ? '0 : fo;
  end

  logic [2:0]        out_st_q;
  logic [CW-1:0]     out_px_q, out_py_q, out_flx_q, out_fly_q, out_fhx_q, out_fhy_q;
  logic [epg_pkg::AXIS_W-1:0] out_fd_q;
  logic [epg_pkg::ECC_W-1:0]  out_ecc_q;
  logic              ok;

  assign ok = mul_st_q == epg_pkg::ST_OK;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_st_q  <= mul_st_q;
      out_px_q  <= ok ? sat_coord(cx + t_x) : '0;
      out_py_q  <= ok ? sat_coord(cy + t_y) : '0;
      out_flx_q <= ok ? sat_coord(cx - fx) : '0;
      out_fhx_q <= ok ? sat_coord(cx + fx) : '0;
      out_fly_q <= ok ? sat_coord(cy - fy) : '0;
      out_fhy_q <= ok ? sat_coord(cy + fy) : '0;
      out_fd_q  <= ok ? focal_i.focal : '0;
      out_ecc_q <= ok ? focal_i.ecc : '0;
    end
  end

  assign out_valid_o      = vld_q[NS-1];
  assign status_o         = out_st_q;
  assign point_x_o        = out_px_q;
  assign point_y_o        = out_py_q;
  assign focus_low_x_o    = out_flx_q;
  assign focus_low_y_o    = out_fly_q;
  assign focus_high_x_o   = out_fhx_q;
  assign focus_high_y_o   = out_fhy_q;
  assign focal_distance_o = out_fd_q;
  assign eccentricity_o   = out_ecc_q;

endmodule

>>> rtl/ellipse_point_generator.sv
// ----------------------------------------------------------------------------
// Ellipse point generator
// Samples points of a configured ellipse and reports its foci
// ----------------------------------------------------------------------------
// Usage:
//   Registers are written through cfg_we_i / cfg_index_i / cfg_data_i; the
//   user must write them only while no request is in flight, which the block
//   itself does not enforce. Each write starts the focal unit (one multiply,
//   31 square-root steps, 16 divide steps); in_ready_o stays low while it runs.
//   A request carries sample_index_i on the in_valid_i / in_ready_o channel.
//   Each request gives one result on out_valid_o / out_ready_i: status,
//   point, both foci, focal distance and eccentricity.
//   The result comes out of the 33-stage pipeline (eight phase divider stages,
//   eighteen Taylor stages).
//   One request is taken every cycle unless the focal unit is busy or the pipeline is full.
//   When the receiver stalls, results pile up in the pipeline stages and
//   empty stages still take requests until the pipeline is full.
//   Reset empties the pipeline and loads the register defaults; the focal
//   values for those defaults are ready at once.
// ----------------------------------------------------------------------------
module ellipse_point_generator #(
  parameter int unsigned MAX_SAMPLES = epg_pkg::MAX_SAMPLES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [epg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [epg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [epg_pkg::IDX_W-1:0]         sample_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [epg_pkg::COORD_BITS-1:0]    point_x_o,
  output logic [epg_pkg::COORD_BITS-1:0]    point_y_o,
  output logic [epg_pkg::COORD_BITS-1:0]    focus_low_x_o,
  output logic [epg_pkg::COORD_BITS-1:0]    focus_low_y_o,
  output logic [epg_pkg::COORD_BITS-1:0]    focus_high_x_o,
  output logic [epg_pkg::COORD_BITS-1:0]    focus_high_y_o,
  output logic [epg_pkg::AXIS_W-1:0]        focal_distance_o,
  output logic [epg_pkg::ECC_W-1:0]         eccentricity_o
);

  epg_pkg::cfg_t   cfg_q;
  epg_pkg::focal_t focal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_y   <= '0;
      cfg_q.major_axis <= epg_pkg::AXIS_W'(65536);
      cfg_q.minor_axis <= epg_pkg::AXIS_W'(65536);
      cfg_q.horizontal <= 1'b1;
      cfg_q.count      <= epg_pkg::IDX_W'(epg_pkg::MIN_SAMPLES);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        epg_pkg::CFG_CENTER_X: cfg_q.center_x   <= cfg_data_i[epg_pkg::COORD_BITS-1:0];
        epg_pkg::CFG_CENTER_Y: cfg_q.center_y   <= cfg_data_i[epg_pkg::COORD_BITS-1:0];
        epg_pkg::CFG_MAJOR:    cfg_q.major_axis <= cfg_data_i[epg_pkg::AXIS_W-1:0];
        epg_pkg::CFG_MINOR:    cfg_q.minor_axis <= cfg_data_i[epg_pkg::AXIS_W-1:0];
        epg_pkg::CFG_HORIZ:    cfg_q.horizontal <= cfg_data_i[0];
        epg_pkg::CFG_COUNT:    cfg_q.count      <= cfg_data_i[epg_pkg::IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  epg_focal u_focal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .cfg_i    (cfg_q),
    .focal_o  (focal)
  );

  epg_pipe #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_pipe (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .focal_i          (focal),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_index_i   (sample_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .point_x_o        (point_x_o),
    .point_y_o        (point_y_o),
    .focus_low_x_o    (focus_low_x_o),
    .focus_low_y_o    (focus_low_y_o),
    .focus_high_x_o   (focus_high_x_o),
    .focus_high_y_o   (focus_high_y_o),
    .focal_distance_o (focal_distance_o),
    .eccentricity_o   (eccentricity_o)
  );

endmodule

>>> rtl/epg_checker.sv
// ----------------------------------------------------------------------------
// Ellipse point generator checker
// Port-level assertions, bound to the top level
// ----------------------------------------------------------------------------
`include "ellipse_point_generator_defines.svh"

module epg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [2:0]                        status_o,
  input logic [epg_pkg::COORD_BITS-1:0]    point_x_o,
  input logic [epg_pkg::COORD_BITS-1:0]    point_y_o,
  input logic [epg_pkg::COORD_BITS-1:0]    focus_low_x_o,
  input logic [epg_pkg::COORD_BITS-1:0]    focus_low_y_o,
  input logic [epg_pkg::COORD_BITS-1:0]    focus_high_x_o,
  input logic [epg_pkg::COORD_BITS-1:0]    focus_high_y_o,
  input logic [epg_pkg::AXIS_W-1:0]        focal_distance_o,
  input logic [epg_pkg::ECC_W-1:0]         eccentricity_o
);

  `EPG_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

  `EPG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(point_x_o) && $stable(point_y_o), "stalled result changed")

  `EPG_ASSERT(a_err_zero, out_valid_o && status_o != epg_pkg::ST_OK |-> point_x_o == '0 && point_y_o == '0 && focus_low_x_o == '0 && focus_low_y_o == '0 && focus_high_x_o == '0 && focus_high_y_o == '0 && focal_distance_o == '0 && eccentricity_o == '0, "error result with data")

  `EPG_ASSERT(a_cfg_busy, cfg_we_i |=> !in_ready_o, "request taken while focal values update")

endmodule

bind ellipse_point_generator epg_checker u_epg_checker (.*);

>>> verif/tb_ellipse_point_generator.sv
// ----------------------------------------------------------------------------
// Ellipse point generator testbench
// Drives sample index requests under several ellipse settings, predicts each
// point, foci, focal distance and eccentricity in fixed point, and compares
// every result field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_ellipse_point_generator;

  typedef struct packed {
    logic [2:0]                     status;
    logic [epg_pkg::COORD_BITS-1:0] px;
    logic [epg_pkg::COORD_BITS-1:0] py;
    logic [epg_pkg::COORD_BITS-1:0] flx;
    logic [epg_pkg::COORD_BITS-1:0] fly;
    logic [epg_pkg::COORD_BITS-1:0] fhx;
    logic [epg_pkg::COORD_BITS-1:0] fhy;
    logic [epg_pkg::AXIS_W-1:0]     focal;
    logic [epg_pkg::ECC_W-1:0]      ecc;
  } ellipse_point_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [epg_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [epg_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [epg_pkg::IDX_W-1:0]       sample_index_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [2:0]                      status_o;
  logic [epg_pkg::COORD_BITS-1:0]  point_x_o, point_y_o;
  logic [epg_pkg::COORD_BITS-1:0]  focus_low_x_o, focus_low_y_o;
  logic [epg_pkg::COORD_BITS-1:0]  focus_high_x_o, focus_high_y_o;
  logic [epg_pkg::AXIS_W-1:0]      focal_distance_o;
  logic [epg_pkg::ECC_W-1:0]       eccentricity_o;

  ellipse_point_generator dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow registers
  logic signed [31:0] sh_cx, sh_cy;
  logic [30:0]        sh_major, sh_minor;
  logic               sh_horiz;
  logic [13:0]        sh_count;

  ellipse_point_t expected_points[$];
  int  errors = 0;
  int  n_requests = 0;
  int  n_results = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] taylor_poly(logic [63:0] x2, bit use_sin);
    logic [63:0] t;
    logic [63:0] d;
    t = 64'd1 << 30;
    for (int k = 0; k < epg_pkg::HORNER_STEPS; k++) begin
      d = use_sin ? epg_pkg::SIN_DIV[k] : epg_pkg::COS_DIV[k];
      t = (64'd1 << 30) - (((x2 * t) >> 30) / d);
    end
    return t;
  endfunction

  function automatic logic signed [63:0] axis_term(logic [63:0] axis, logic signed [63:0] trig);
    logic [63:0] m, p;
    m = trig < 0 ? -trig : trig;
    p = (axis * m + (64'd1 << 29)) >> 30;
    return trig < 0 ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic ellipse_point_t predict_point(logic [13:0] idx);
    ellipse_point_t e;
    logic [63:0] a, b, n, c, ph, r, x, x2, s0, c0, tmp;
    logic [1:0] q;
    logic signed [63:0] cs, sn, tmaj, tmin, cx, cy, cc;
    e = '0;
    a = sh_major;
    b = sh_minor;
    n = sh_count;
    if (a == 0 || b == 0) e.status = epg_pkg::ST_AXIS;
    else if (n < epg_pkg::MIN_SAMPLES || n > epg_pkg::MAX_SAMPLES) e.status = epg_pkg::ST_COUNT;
    else if (a < b) e.status = epg_pkg::ST_ORDER;
    else if (idx >= n) e.status = epg_pkg::ST_INDEX;
    else e.status = epg_pkg::ST_OK;
    if (e.status != epg_pkg::ST_OK) return e;
    c = int_sqrt(a * a - b * b);
    ph = ((({50'd0, idx}) << 32) + (n - 1) / 2) / (n - 1);
    q = ph[31:30];
    r = ph[29:0];
    tmp = (r <= (64'd1 << 29)) ? r : (64'd1 << 30) - r;
    x = (tmp * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    s0 = (x * taylor_poly(x2, 1'b1)) >> 30;
    c0 = taylor_poly(x2, 1'b0);
    if (r > (64'd1 << 29)) begin
      tmp = s0;
      s0 = c0;
      c0 = tmp;
    end
    case (q)
      2'd0: begin cs = c0; sn = s0; end
      2'd1: begin cs = -$signed(s0); sn = c0; end
      2'd2: begin cs = -$signed(c0); sn = -$signed(s0); end
      default: begin cs = s0; sn = -$signed(c0); end
    endcase
    tmaj = axis_term(a, cs);
    tmin = axis_term(b, sn);
    cx = sh_cx;
    cy = sh_cy;
    cc = c;
    if (sh_horiz) begin
      e.px = clamp32(cx + tmaj);
      e.py = clamp32(cy + tmin);
      e.flx = clamp32(cx - cc);
      e.fhx = clamp32(cx + cc);
      e.fly = sh_cy;
      e.fhy = sh_cy;
    end else begin
      e.px = clamp32(cx + tmin);
      e.py = clamp32(cy + tmaj);
      e.flx = sh_cx;
      e.fhx = sh_cx;
      e.fly = clamp32(cy - cc);
      e.fhy = clamp32(cy + cc);
    end
    e.focal = c[30:0];
    e.ecc = 17'((c << epg_pkg::FRAC_BITS) / a);
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic write_reg(epg_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      epg_pkg::CFG_CENTER_X: sh_cx = data;
      epg_pkg::CFG_CENTER_Y: sh_cy = data;
      epg_pkg::CFG_MAJOR:    sh_major = data[30:0];
      epg_pkg::CFG_MINOR:    sh_minor = data[30:0];
      epg_pkg::CFG_HORIZ:    sh_horiz = data[0];
      default:               sh_count = data[13:0];
    endcase
  endtask

  task automatic set_ellipse(logic [31:0] cx, logic [31:0] cy, logic [31:0] maj,
                             logic [31:0] mnr, logic [31:0] hz, logic [31:0] cnt);
    in_valid_i <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (40) @(posedge clk_i);
    write_reg(epg_pkg::CFG_CENTER_X, cx);
    write_reg(epg_pkg::CFG_CENTER_Y, cy);
    write_reg(epg_pkg::CFG_MAJOR, maj);
    write_reg(epg_pkg::CFG_MINOR, mnr);
    write_reg(epg_pkg::CFG_HORIZ, hz);
    write_reg(epg_pkg::CFG_COUNT, cnt);
  endtask

  task automatic send_index(logic [13:0] idx);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_points.insert(expected_points.size(), predict_point(idx));
    n_requests++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ellipse_point_t w;
      n_results++;
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result status", status_o, '0);
      end else begin
        w = expected_points.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (point_x_o !== w.px) report_mismatch("point_x", point_x_o, w.px);
        if (point_y_o !== w.py) report_mismatch("point_y", point_y_o, w.py);
        if (focus_low_x_o !== w.flx) report_mismatch("focus_low_x", focus_low_x_o, w.flx);
        if (focus_low_y_o !== w.fly) report_mismatch("focus_low_y", focus_low_y_o, w.fly);
        if (focus_high_x_o !== w.fhx) report_mismatch("focus_high_x", focus_high_x_o, w.fhx);
        if (focus_high_y_o !== w.fhy) report_mismatch("focus_high_y", focus_high_y_o, w.fhy);
        if (focal_distance_o !== w.focal)
          report_mismatch("focal_distance", focal_distance_o, w.focal);
        if (eccentricity_o !== w.ecc) report_mismatch("eccentricity", eccentricity_o, w.ecc);
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic test_reset_defaults();
    sh_cx = 0; sh_cy = 0; sh_major = 65536; sh_minor = 65536; sh_horiz = 1; sh_count = 4;
    for (int i = 0; i < 6; i++) send_index(14'(i));
    send_index(14'h3fff);
  endtask

  task automatic test_directed();
    set_ellipse(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 1, 10000);
    send_index(14'd0); send_index(14'd2500); send_index(14'd5000); send_index(14'd7500);
    send_index(14'd9999);
    send_index(14'd10000);
    set_ellipse(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001, 0, 5);
    for (int i = 0; i < 5; i++) send_index(14'(i));
    set_ellipse(0, 0, 0, 32'h10000, 1, 8);
    send_index(14'd1);
    set_ellipse(0, 0, 32'h10000, 0, 1, 8);
    send_index(14'd1);
    set_ellipse(0, 0, 32'h10000, 32'h20000, 1, 3);
    send_index(14'd1);
    set_ellipse(0, 0, 32'h10000, 32'h20000, 1, 10001);
    send_index(14'd1);
    set_ellipse(0, 0, 32'h10000, 32'h20000, 1, 16383);
    send_index(14'd1);
    set_ellipse(0, 0, 32'h10000, 32'h20000, 1, 8);
    send_index(14'd1);
  endtask

  task automatic test_random_sweeps();
    logic [31:0] maj, mnr;
    for (int ph = 0; ph < 12; ph++) begin
      maj = $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 32'h0100_0000);
      mnr = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, maj[30:0] == 0 ? 1 : maj[30:0]);
      if (ph == 11) begin
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
      end
      set_ellipse($urandom, $urandom, maj, mnr, $urandom,
                  $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(4, 300));
      for (int k = 0; k < 42; k++)
        send_index(14'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, sh_count)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_sweeps();
    in_valid_i <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("covered %0d requests and %0d results over directed and random ellipses",
             n_requests, n_results);
    if (errors == 0 && expected_points.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
